// ----- rtl/csvp_pkg.sv -----
// ----------------------------------------------------------------------------
// csvp_pkg
// shared types and constants of the csv quoted field parser
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int FNUM_W     = 6;
  localparam int EXPF_W     = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [FNUM_W-1:0] FIELD_LAST = FNUM_W'(MAX_FIELDS - 1);

  localparam logic [EXPF_W-1:0] EXPECTED_FIELDS_RST = 7'd35;

  localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_FIELDS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SKIP_HEADER     = 1'd1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_COUNT   = 2'd1,
    ERR_STRAY   = 2'd2,
    ERR_UNTERM  = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        char_out;
    logic              data_valid;
    logic [FNUM_W-1:0] field_number;
    logic              field_done;
    logic              record_done;
    err_t              error_code;
  } result_t;

endpackage

// ----- rtl/csvp_in_reg.sv -----
// ----------------------------------------------------------------------------
// csvp_in_reg
// input beat register in front of the parser step
// ----------------------------------------------------------------------------
module csvp_in_reg
  import csvp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  input  logic     advance,
  output logic     held_valid,
  output in_beat_t held_beat
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

// ----- rtl/csvp_core.sv -----
// ----------------------------------------------------------------------------
// csvp_core
// parser state and the per-byte step that forms one result
// ----------------------------------------------------------------------------
module csvp_core
  import csvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  in_beat_t          beat,
  input  logic [EXPF_W-1:0] expected_fields,
  input  logic              skip_header,
  output result_t           res,
  output logic              res_has
);

  logic              inside_quotes;
  logic              quote_pending;
  logic              at_field_start;
  logic [FNUM_W-1:0] field_counter;
  logic              header_passed;
  logic              line_empty;

  logic              inside_quotes_next;
  logic              quote_pending_next;
  logic              at_field_start_next;
  logic [FNUM_W-1:0] field_counter_next;
  logic              header_passed_next;
  logic              line_empty_next;

  always_comb begin
    logic [7:0] c;
    logic       do_unq;
    logic       close_req;
    c         = beat.char_in;
    do_unq    = 1'b0;
    close_req = 1'b0;

    inside_quotes_next  = inside_quotes;
    quote_pending_next  = quote_pending;
    at_field_start_next = at_field_start;
    field_counter_next  = field_counter;
    header_passed_next  = header_passed;
    line_empty_next     = line_empty;
    res                 = '0;
    res.error_code      = ERR_OK;
    res_has             = 1'b0;

    if (skip_header && !header_passed) begin
      if (c == CH_LF) begin
        header_passed_next = 1'b1;
      end
    end else begin
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (c == CH_QUOTE) begin
          res.char_out     = c;
          res.data_valid   = 1'b1;
          res.field_number = field_counter;
          res_has          = 1'b1;
          line_empty_next  = 1'b0;
        end else begin
          inside_quotes_next = 1'b0;
          do_unq             = 1'b1;
        end
      end else if (inside_quotes) begin
        if (c == CH_QUOTE) begin
          quote_pending_next = 1'b1;
        end else begin
          res.char_out     = c;
          res.data_valid   = 1'b1;
          res.field_number = field_counter;
          res_has          = 1'b1;
          line_empty_next  = 1'b0;
        end
      end else begin
        do_unq = 1'b1;
      end

      if (do_unq) begin
        if (c == CH_QUOTE) begin
          line_empty_next = 1'b0;
          if (at_field_start) begin
            inside_quotes_next  = 1'b1;
            at_field_start_next = 1'b0;
          end else begin
            res_has          = 1'b1;
            res.field_number = field_counter;
            res.error_code   = ERR_STRAY;
          end
        end else if (c == CH_COMMA) begin
          res_has             = 1'b1;
          res.field_done      = 1'b1;
          res.field_number    = field_counter;
          at_field_start_next = 1'b1;
          line_empty_next     = 1'b0;
          if (field_counter == FIELD_LAST) begin
            res.error_code = ERR_COUNT;
          end else begin
            field_counter_next = field_counter + 1'b1;
          end
        end else if (c == CH_LF) begin
          close_req = !line_empty;
        end else if (c != CH_CR) begin
          res.char_out        = c;
          res.data_valid      = 1'b1;
          res.field_number    = field_counter;
          res_has             = 1'b1;
          line_empty_next     = 1'b0;
          at_field_start_next = 1'b0;
        end
      end

      // byte after a closing quote that does not end the field
      if (quote_pending && c != CH_QUOTE && c != CH_COMMA && c != CH_LF && c != CH_CR) begin
        if (ERR_STRAY > res.error_code) begin
          res.error_code = ERR_STRAY;
        end
      end

      if (beat.last_in) begin
        if (inside_quotes_next && !quote_pending_next) begin
          res.error_code = ERR_UNTERM;
          close_req      = 1'b1;
        end else if (!line_empty_next) begin
          close_req = 1'b1;
        end
      end

      if (close_req) begin
        res_has          = 1'b1;
        res.field_done   = 1'b1;
        res.record_done  = 1'b1;
        res.field_number = field_counter_next;
        if (({1'b0, field_counter_next} + 7'd1) != expected_fields) begin
          if (ERR_COUNT > res.error_code) begin
            res.error_code = ERR_COUNT;
          end
        end
        field_counter_next  = '0;
        at_field_start_next = 1'b1;
        line_empty_next     = 1'b1;
      end
    end

    if (beat.last_in) begin
      inside_quotes_next  = 1'b0;
      quote_pending_next  = 1'b0;
      at_field_start_next = 1'b1;
      field_counter_next  = '0;
      header_passed_next  = 1'b0;
      line_empty_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes  <= 1'b0;
      quote_pending  <= 1'b0;
      at_field_start <= 1'b1;
      field_counter  <= '0;
      header_passed  <= 1'b0;
      line_empty     <= 1'b1;
    end else if (advance) begin
      inside_quotes  <= inside_quotes_next;
      quote_pending  <= quote_pending_next;
      at_field_start <= at_field_start_next;
      field_counter  <= field_counter_next;
      header_passed  <= header_passed_next;
      line_empty     <= line_empty_next;
    end
  end

`ifndef SYNTHESIS
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> inside_quotes)
    else $error("closing quote pending outside a quoted field");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    advance && beat.last_in |=> !inside_quotes && !quote_pending && at_field_start &&
                                field_counter == '0 && !header_passed && line_empty)
    else $error("state not back to start after final byte");

  a_record_closes_field: assert property (@(posedge clk) disable iff (rst)
    advance && res_has && res.record_done |-> res.field_done)
    else $error("record closed without closing its field");

  a_unterm_only_at_end: assert property (@(posedge clk) disable iff (rst)
    advance && res_has && res.error_code == ERR_UNTERM |-> beat.last_in && res.record_done)
    else $error("open quote reported before end of input");
`endif

endmodule

// ----- rtl/csvp_out_reg.sv -----
// ----------------------------------------------------------------------------
// csvp_out_reg
// result register toward the output stream
// ----------------------------------------------------------------------------
module csvp_out_reg
  import csvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_space,
  output result_t out_res
);

  assign out_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ----- rtl/csv_quoted_field_parser.sv -----
// ----------------------------------------------------------------------------
// csv_quoted_field_parser
// streaming csv parser with quoted field handling, one byte per beat
// ----------------------------------------------------------------------------
// Takes one byte of csv text per cycle unless the output stalls, and gives at
// most one result per byte, registered first in the input register and then in
// the result register; throughput is set by the single parser step between them.
// Quotes are stripped, a doubled quote becomes one quote, cr outside quotes and
// empty lines are dropped, and the header line is dropped when skip_header is
// set. The final byte (tlast) closes the open record and returns the parser to its
// start state. Registers: 0 expected_fields (reset 35), 1 skip_header (reset 1);
// write only while the stream is idle.
module csv_quoted_field_parser
  import csvp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // char_in
  input  logic                  s_tlast,   // last_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // char_out, field_number, field_done, pad
  output logic                  m_tlast,   // record_done
  output logic [2:0]            m_tuser,   // data_valid, error_code
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [EXPF_W-1:0] expected_fields;
  logic              skip_header;

  in_beat_t in_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     advance;
  logic     out_space;
  result_t  step_res;
  logic     step_has;
  result_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_fields <= EXPECTED_FIELDS_RST;
      skip_header     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EXPECTED_FIELDS: expected_fields <= cfg_wdata[EXPF_W-1:0];
        REG_SKIP_HEADER:     skip_header     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_beat.char_in = s_tdata;
  assign in_beat.last_in = s_tlast;
  assign advance         = held_valid && out_space;

  csvp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_beat    (in_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  csvp_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .beat            (held_beat),
    .expected_fields (expected_fields),
    .skip_header     (skip_header),
    .res             (step_res),
    .res_has         (step_has)
  );

  csvp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step_has),
    .load_res  (step_res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_space (out_space),
    .out_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res.field_done, out_res.field_number, out_res.char_out};
  assign m_tlast = out_res.record_done;
  assign m_tuser = {out_res.error_code, out_res.data_valid};

endmodule
